>>> rtl/core/fqdel_pkg.sv
// Shared constants and types for the queue with delete by value.
`default_nettype none
package fqdel_pkg;

  // Default geometry.
  localparam int unsigned DEPTH_DEFAULT       = 16;
  localparam int unsigned VALUE_WIDTH_DEFAULT = 32;

  // Fixed widths of the item fields.
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // Operation strobes broadcast from the control logic to every cell.
  typedef struct packed {
    logic op_add;     // append the key at the first free cell
    logic op_remove;  // every cell takes its right neighbor's entry
    logic op_delete;  // cells at and after the first match take their right neighbor
  } ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/fqdel_cell.sv
// One storage cell of the queue: holds one entry, compares it and shifts toward the head.
`default_nettype none
module fqdel_cell #(
  parameter int unsigned VALUE_WIDTH = fqdel_pkg::VALUE_WIDTH_DEFAULT,
  parameter int unsigned CNT_W       = 5,
  parameter int unsigned INDEX       = 0
) (
  input  wire logic                   clk,
  input  wire fqdel_pkg::ctl_t        ctl,
  input  wire logic [VALUE_WIDTH-1:0] key,
  input  wire logic [CNT_W-1:0]       count,
  input  wire logic [VALUE_WIDTH-1:0] right_value,
  input  wire logic                   hit_in,
  output logic                        hit_out,
  output logic [VALUE_WIDTH-1:0]      entry
);

  logic live;
  logic match;
  logic shift;
  logic load;

  // The cell holds a valid entry when its position is below the fill count.
  assign live    = CNT_W'(INDEX) < count;
  assign match   = live && (entry == key);
  assign hit_out = hit_in | match;

  assign shift = ctl.op_remove | (ctl.op_delete & hit_out);
  assign load  = ctl.op_add && (count == CNT_W'(INDEX));

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= key;
    end else if (shift) begin
      entry <= right_value;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/fifo_queue_with_delete_by_value.sv
// Top level of the bounded queue with add, remove-head and delete-by-value.
//
// The queue is a row of QUEUE_DEPTH cells, cell 0 being the head. Each item
// (start high while busy is low) carries one operation in mode: add appends
// value at the tail, remove takes the head entry, delete removes the first
// entry from the head that equals value, and the later entries close up in
// order. Every cell compares its entry with the key in parallel, a one-bit
// match chain marks the cells at and after the first match, and those cells
// load their right neighbor's entry at the same clock edge, so an item can be
// started in every cycle: busy stays low.
// The result of an item appears on removed_value, status and entry_count in
// the cycle after it was accepted, marked by done for exactly one cycle. The
// receiver cannot stall the block, so it must take each result when done is
// high. removed_value is the head entry on a successful remove and zero
// otherwise; status reports an empty queue on remove, a value not found on
// delete, or a full queue on add (the value is then dropped). An undefined
// mode changes nothing and reports ok. entry_count is the number of entries
// held after the operation. Values are stored and compared in VALUE_WIDTH
// bits; only the low VALUE_WIDTH bits of value are used, and a stored value
// narrower than 32 bits is returned zero-extended.
`default_nettype none
module fifo_queue_with_delete_by_value #(
  parameter int unsigned QUEUE_DEPTH = fqdel_pkg::DEPTH_DEFAULT,
  parameter int unsigned VALUE_WIDTH = fqdel_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [fqdel_pkg::MODE_W-1:0]        mode,
  input  wire logic signed [fqdel_pkg::DATA_W-1:0] value,
  output logic                                     done,
  output logic signed [fqdel_pkg::DATA_W-1:0]      removed_value,
  output logic [fqdel_pkg::STATUS_W-1:0]           status,
  output logic [fqdel_pkg::COUNT_W-1:0]            entry_count
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  // Common width for converting between the port and the storage width.
  localparam int unsigned WIDE_W =
    (VALUE_WIDTH > fqdel_pkg::DATA_W) ? VALUE_WIDTH : fqdel_pkg::DATA_W;
  localparam int unsigned CWIDE_W =
    (CNT_W > fqdel_pkg::COUNT_W) ? CNT_W : fqdel_pkg::COUNT_W;

  // Fill count of the cell row; cells at and above it hold no entry.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic                   accept;
  logic                   is_add;
  logic                   is_remove;
  logic                   is_delete;
  logic                   empty;
  logic                   full;
  logic                   found;
  fqdel_pkg::ctl_t        ctl;
  logic [WIDE_W-1:0]      key_wide;
  logic [VALUE_WIDTH-1:0] key;
  logic [WIDE_W-1:0]      head_wide;
  logic [CWIDE_W-1:0]     count_wide;

  logic [fqdel_pkg::STATUS_W-1:0] status_next;
  logic [fqdel_pkg::DATA_W-1:0]   removed_next;

  logic [VALUE_WIDTH-1:0] cell_value [QUEUE_DEPTH];
  logic                   hit        [QUEUE_DEPTH+1];

  // Busy is tied low: the block never holds off a start.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign key_wide = WIDE_W'($unsigned(value));
  assign key      = key_wide[VALUE_WIDTH-1:0];

  assign is_add    = accept && (mode == fqdel_pkg::MODE_ADD);
  assign is_remove = accept && (mode == fqdel_pkg::MODE_REMOVE);
  assign is_delete = accept && (mode == fqdel_pkg::MODE_DELETE);

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(QUEUE_DEPTH));

  // A delete that finds nothing leaves every match flag low, so no cell shifts.
  assign ctl.op_add    = is_add && !full;
  assign ctl.op_remove = is_remove && !empty;
  assign ctl.op_delete = is_delete;

  assign hit[0] = 1'b0;
  assign found  = hit[QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] right_value;

    // The tail cell has no right neighbor; what it loads on a shift lies
    // beyond the fill count and is never read.
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    fqdel_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CNT_W       (CNT_W),
      .INDEX       (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .key         (key),
      .count       (count),
      .right_value (right_value),
      .hit_in      (hit[i]),
      .hit_out     (hit[i+1]),
      .entry       (cell_value[i])
    );
  end

  assign head_wide = WIDE_W'(cell_value[0]);

  always_comb begin
    count_next   = count;
    status_next  = fqdel_pkg::ST_OK;
    removed_next = '0;
    priority if (is_add) begin
      if (full) begin
        status_next = fqdel_pkg::ST_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else if (is_remove) begin
      if (empty) begin
        status_next = fqdel_pkg::ST_EMPTY;
      end else begin
        count_next   = count - CNT_W'(1);
        removed_next = head_wide[fqdel_pkg::DATA_W-1:0];
      end
    end else if (is_delete) begin
      if (found) begin
        count_next = count - CNT_W'(1);
      end else begin
        status_next = fqdel_pkg::ST_NOT_FOUND;
      end
    end else begin
      count_next = count;
    end
  end

  assign count_wide = CWIDE_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // Result registers hold payload only and need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      removed_value <= $signed(removed_next);
      status        <= status_next;
      entry_count   <= count_wide[fqdel_pkg::COUNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/fqdel_check.sv
// Port-level checker for the queue with delete by value, bound to the top level.
`default_nettype none
module fqdel_check #(
  parameter int unsigned QUEUE_DEPTH = fqdel_pkg::DEPTH_DEFAULT
) (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic                                done,
  input wire logic signed [fqdel_pkg::DATA_W-1:0] removed_value,
  input wire logic [fqdel_pkg::STATUS_W-1:0]      status,
  input wire logic [fqdel_pkg::COUNT_W-1:0]       entry_count
);

  localparam logic [fqdel_pkg::COUNT_W-1:0] FULL_COUNT =
    fqdel_pkg::COUNT_W'(QUEUE_DEPTH);

  // Each accepted item gives its result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("no result in the cycle after an accepted item");

  // No result appears without an item accepted in the cycle before.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without an accepted item");

  // A failed remove reports an empty queue and returns no value.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && status == fqdel_pkg::ST_EMPTY) |-> (entry_count == '0 && removed_value == '0))
    else $error("empty status with nonzero count or value");

  // A dropped add reports the queue as full.
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (done && status == fqdel_pkg::ST_FULL) |-> (entry_count == FULL_COUNT
      && removed_value == '0))
    else $error("full status with wrong count or nonzero value");

endmodule

bind fifo_queue_with_delete_by_value fqdel_check #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_fqdel_check (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .removed_value (removed_value),
  .status        (status),
  .entry_count   (entry_count)
);
`default_nettype wire
